// ----- sv/vfz_pkg.sv -----
// ----------------------------------------------------------------------------
// vfz_pkg: shared types and constants for the viewport follow/zoom block
// Register map, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package vfz_pkg;

	localparam int EASE_DIVISOR_DEF = 15;
	localparam int DVD_W = 27;   // boundary << 12 needs 27 bits
	localparam int DVS_W = 13;   // base size width
	localparam int ZOOM_FLOOR = 819;

	localparam logic [12:0] BASE_W_RST = 13'd640;
	localparam logic [12:0] BASE_H_RST = 13'd480;
	localparam logic [15:0] BND_L_RST = 16'hFC18;   // -1000
	localparam logic [15:0] BND_T_RST = 16'hFC18;
	localparam logic [14:0] BND_W_RST = 15'd3000;
	localparam logic [14:0] BND_H_RST = 15'd3000;
	localparam logic [15:0] ZLIM_RST = 16'd4096;
	localparam logic [12:0] ZSTEP_RST = 13'd41;
	localparam logic [15:0] ZOOM_RST = 16'd4096;

	typedef enum logic [2:0] {
		REG_BASE_W  = 3'd0,
		REG_BASE_H  = 3'd1,
		REG_BND_L   = 3'd2,
		REG_BND_T   = 3'd3,
		REG_BND_W   = 3'd4,
		REG_BND_H   = 3'd5,
		REG_ZLIM    = 3'd6,
		REG_ZSTEP   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EASE,
		S_DIV,
		S_EAPPLY,
		S_ESNAP,
		S_FITA,
		S_FITB,
		S_FITC,
		S_ZOOM,
		S_FITW,
		S_FITW2,
		S_FITH,
		S_FITH2,
		S_ZFIN,
		S_SCMW,
		S_SCWW,
		S_SCMH,
		S_SCWH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DVD_W-1:0]     dividend;
		logic [DVS_W-1:0]     divisor;
	} div_req_t;

endpackage

// ----- sv/viewport_follow_zoom.sv -----
// ----------------------------------------------------------------------------
// viewport_follow_zoom: camera window that eases toward a target and zooms
// Sequenced datapath with a shared window-scale multiplier, an ease multiplier and one shared divider.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------------------------
//  input   | in_valid, in_stall, target_*    | frame request into block
//  output  | out_valid, out_stall, view_*    | window result out of block
//  config  | cfg_valid, cfg_ready, cfg_*     | register writes, always ready
//
//  Each eased axis uses a reciprocal multiply for the ease step, each window
//  rescale uses the window-scale multiplier, and each boundary fit of the zoom uses
//  the divider plus a rescale. A waiting result holds the request in S_DONE until
//  the output register is free to take it.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a stalled result holds and blocks only the next request.
//  Reset restores register defaults, centre 0, zoom 1.0 and base window.
// ----------------------------------------------------------------------------
module viewport_follow_zoom #(
	parameter int EASE_DIVISOR = vfz_pkg::EASE_DIVISOR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] target_x,
	input  logic signed [23:0] target_y,
	input  logic [15:0]        target_zoom,
	input  logic               jump,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] view_left,
	output logic signed [23:0] view_top,
	output logic [23:0]        view_width,
	output logic [23:0]        view_height,
	output logic [15:0]        zoom_now,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int DW = vfz_pkg::DVD_W;
	// exact truncated division of a 24 bit magnitude by a reciprocal multiply
	localparam int EASE_SH = 24 + $clog2(EASE_DIVISOR);
	localparam logic [25:0] EASE_RECIP = 26'(((64'd1 << EASE_SH) + 64'(EASE_DIVISOR)
		- 64'd1) / 64'(EASE_DIVISOR));

	// configuration
	logic [12:0]        bw_q, bh_q, zstep_q;
	logic signed [15:0] bl_q, bt_q;
	logic [14:0]        bdw_q, bdh_q;
	logic [15:0]        zlim_q;

	vfz_pkg::state_t state_q, state_d, ret_q;

	logic               ax_q, dir_q, sw_q, sh_q;
	logic signed [23:0] tx_q, ty_q, cx_q, cy_q, left_q, top_q;
	logic [15:0]        tz_q, zl_q;
	logic [DW-1:0]      zw_q;
	logic [23:0]        ww_q, wh_q;
	logic [39:0]        prod_q;
	logic [55:0]        emul_q;
	logic signed [27:0] off_q, hw_q;

	logic               out_valid_q;
	logic signed [23:0] ol_q, ot_q;
	logic [23:0]        ow_q, oh_q;
	logic [15:0]        oz_q;

	vfz_pkg::div_req_t  dreq;
	logic               div_done;
	logic [DW-1:0]      quo;

	logic               accept, out_free;

	// shared selections by axis
	logic signed [23:0] p_sel, t_sel;
	logic [23:0]        w_sel;
	logic signed [15:0] edge_sel;
	logic [14:0]        span_sel;
	logic signed [24:0] gap;
	logic [23:0]        gap_mag;
	logic [23:0]        ease_quo;
	logic signed [25:0] p_ease, v_snap, tr_snap, r256;
	logic               snap_hit;
	logic signed [27:0] lo, off_a, off_lo, hw_a, half, cen_c;
	logic signed [16:0] zgap;
	logic [16:0]        zgap_mag;
	logic signed [17:0] zn;
	logic [15:0]        zn_clamp, tz_clamp;
	logic [12:0]        mul_a;
	logic [40:0]        rnd;
	logic [23:0]        scaled_v;
	logic               fitw_hit, fith_hit;

	function automatic logic [15:0] clamp_zoom(input logic signed [17:0] z,
			input logic [15:0] lim);
		logic signed [17:0] r;
		r = z;
		if (r <= 18'sd819) r = 18'sd819;
		if (r > $signed({2'b00, lim})) r = $signed({2'b00, lim});
		return r[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
		if (v > 28'sd8388607) return 24'sh7FFFFF;
		if (v < -28'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != vfz_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	assign p_sel = ax_q ? cy_q : cx_q;
	assign t_sel = ax_q ? ty_q : tx_q;
	assign w_sel = ax_q ? wh_q : ww_q;
	assign edge_sel = ax_q ? bt_q : bl_q;
	assign span_sel = ax_q ? bdh_q : bdw_q;

	assign gap = 25'(t_sel) - 25'(p_sel);
	assign gap_mag = gap[24] ? 24'(-gap) : 24'(gap);
	assign ease_quo = emul_q[EASE_SH +: 24];

	assign p_ease = dir_q ? 26'(p_sel) + $signed({2'b0, ease_quo})
	                      : 26'(p_sel) - $signed({2'b0, ease_quo});

	// pixel rounding truncates toward zero
	assign v_snap = dir_q ? 26'(p_sel) + 26'sd128 : 26'(p_sel) - 26'sd128;
	assign tr_snap = v_snap[25] ? v_snap + 26'sd255 : v_snap;
	assign r256 = {tr_snap[25:8], 8'b0};
	assign snap_hit = dir_q ? (r256 >= 26'(t_sel)) : (r256 <= 26'(t_sel));

	assign lo = 28'(edge_sel) <<< 8;
	assign half = $signed({4'b0, 1'b0, w_sel[23:1]});
	assign off_a = 28'(p_sel) - half;
	assign off_lo = (off_a < lo) ? lo : off_a;
	assign hw_a = lo + $signed({5'b0, span_sel, 8'b0}) - $signed({4'b0, w_sel});
	assign cen_c = off_q + half;

	assign zgap = $signed({1'b0, tz_q}) - $signed({1'b0, zl_q});
	assign zgap_mag = zgap[16] ? 17'(-zgap) : 17'(zgap);
	assign zn = (zl_q < tz_q) ? $signed({2'b0, zl_q}) + $signed({5'b0, zstep_q})
	                          : $signed({2'b0, zl_q}) - $signed({5'b0, zstep_q});
	assign zn_clamp = clamp_zoom(zn, zlim_q);
	assign tz_clamp = clamp_zoom($signed({2'b0, target_zoom}), zlim_q);

	assign mul_a = (state_q == vfz_pkg::S_SCMW) ? bw_q : bh_q;
	assign rnd = {1'b0, prod_q} + 41'd8;
	assign scaled_v = (rnd[40:4] > 37'hFFFFFF) ? 24'hFFFFFF : rnd[27:4];

	assign fitw_hit = (bw_q != 13'd0) && (ww_q > {1'b0, bdw_q, 8'b0});
	assign fith_hit = (bh_q != 13'd0) && (wh_q > {1'b0, bdh_q, 8'b0});

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = {bdw_q, 12'b0};
		dreq.divisor = bw_q;
		case (state_q)
			vfz_pkg::S_FITW: begin
				dreq.start = fitw_hit;
				dreq.dividend = {bdw_q, 12'b0};
				dreq.divisor = bw_q;
			end
			vfz_pkg::S_FITH: begin
				dreq.start = fith_hit;
				dreq.dividend = {bdh_q, 12'b0};
				dreq.divisor = bh_q;
			end
			default: ;
		endcase
	end

	vfz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= vfz_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vfz_pkg::S_IDLE: if (accept) state_d = jump ? vfz_pkg::S_SCMW : vfz_pkg::S_EASE;
			vfz_pkg::S_EASE: begin
				if (gap != 25'sd0) state_d = vfz_pkg::S_EAPPLY;
				else state_d = ax_q ? vfz_pkg::S_FITA : vfz_pkg::S_EASE;
			end
			vfz_pkg::S_DIV: if (div_done) state_d = ret_q;
			vfz_pkg::S_EAPPLY: state_d = vfz_pkg::S_ESNAP;
			vfz_pkg::S_ESNAP: state_d = ax_q ? vfz_pkg::S_FITA : vfz_pkg::S_EASE;
			vfz_pkg::S_FITA: state_d = vfz_pkg::S_FITB;
			vfz_pkg::S_FITB: state_d = vfz_pkg::S_FITC;
			vfz_pkg::S_FITC: state_d = ax_q ? vfz_pkg::S_ZOOM : vfz_pkg::S_FITA;
			vfz_pkg::S_ZOOM: state_d = (zl_q == tz_q) ? vfz_pkg::S_DONE : vfz_pkg::S_SCMW;
			vfz_pkg::S_FITW: state_d = fitw_hit ? vfz_pkg::S_DIV : vfz_pkg::S_FITH;
			vfz_pkg::S_FITW2: state_d = vfz_pkg::S_SCMW;
			vfz_pkg::S_FITH: state_d = fith_hit ? vfz_pkg::S_DIV : vfz_pkg::S_ZFIN;
			vfz_pkg::S_FITH2: state_d = vfz_pkg::S_SCMW;
			vfz_pkg::S_ZFIN: state_d = vfz_pkg::S_DONE;
			vfz_pkg::S_SCMW: state_d = vfz_pkg::S_SCWW;
			vfz_pkg::S_SCWW: state_d = vfz_pkg::S_SCMH;
			vfz_pkg::S_SCMH: state_d = vfz_pkg::S_SCWH;
			vfz_pkg::S_SCWH: state_d = ret_q;
			vfz_pkg::S_DONE: if (out_free) state_d = vfz_pkg::S_IDLE;
			default: state_d = vfz_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= vfz_pkg::BASE_W_RST;
			bh_q <= vfz_pkg::BASE_H_RST;
			bl_q <= vfz_pkg::BND_L_RST;
			bt_q <= vfz_pkg::BND_T_RST;
			bdw_q <= vfz_pkg::BND_W_RST;
			bdh_q <= vfz_pkg::BND_H_RST;
			zlim_q <= vfz_pkg::ZLIM_RST;
			zstep_q <= vfz_pkg::ZSTEP_RST;
			cx_q <= '0;
			cy_q <= '0;
			zl_q <= vfz_pkg::ZOOM_RST;
			ww_q <= {3'b0, vfz_pkg::BASE_W_RST, 8'b0};
			wh_q <= {3'b0, vfz_pkg::BASE_H_RST, 8'b0};
			ax_q <= 1'b0;
			ret_q <= vfz_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (vfz_pkg::reg_idx_t'(cfg_index))
					vfz_pkg::REG_BASE_W: bw_q <= cfg_data[12:0];
					vfz_pkg::REG_BASE_H: bh_q <= cfg_data[12:0];
					vfz_pkg::REG_BND_L:  bl_q <= cfg_data;
					vfz_pkg::REG_BND_T:  bt_q <= cfg_data;
					vfz_pkg::REG_BND_W:  bdw_q <= cfg_data[14:0];
					vfz_pkg::REG_BND_H:  bdh_q <= cfg_data[14:0];
					vfz_pkg::REG_ZLIM:   zlim_q <= cfg_data;
					vfz_pkg::REG_ZSTEP:  zstep_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			// load a new result, or drop the one taken by the receiver
			if (state_q == vfz_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				vfz_pkg::S_IDLE: if (accept) begin
					ax_q <= 1'b0;
					if (jump) begin
						cx_q <= target_x;
						cy_q <= target_y;
						zl_q <= tz_clamp;
						ret_q <= vfz_pkg::S_EASE;
					end
				end
				vfz_pkg::S_EASE: begin
					if (gap == 25'sd0) ax_q <= ~ax_q;
				end
				vfz_pkg::S_EAPPLY: begin
					if (ax_q) cy_q <= p_ease[23:0];
					else cx_q <= p_ease[23:0];
				end
				vfz_pkg::S_ESNAP: begin
					if (snap_hit) begin
						if (ax_q) cy_q <= ty_q;
						else cx_q <= tx_q;
					end
					ax_q <= ~ax_q;
				end
				vfz_pkg::S_FITC: begin
					if (ax_q) cy_q <= sat24(cen_c);
					else cx_q <= sat24(cen_c);
					ax_q <= ~ax_q;
				end
				vfz_pkg::S_ZOOM: begin
					if (zgap_mag <= {4'b0, zstep_q}) ret_q <= vfz_pkg::S_ZFIN;
					else ret_q <= vfz_pkg::S_FITW;
				end
				vfz_pkg::S_FITW: ret_q <= vfz_pkg::S_FITW2;
				vfz_pkg::S_FITW2: begin
					ww_q <= {1'b0, bdw_q, 8'b0};
					ret_q <= vfz_pkg::S_FITH;
				end
				vfz_pkg::S_FITH: ret_q <= vfz_pkg::S_FITH2;
				vfz_pkg::S_FITH2: begin
					wh_q <= {1'b0, bdh_q, 8'b0};
					ret_q <= vfz_pkg::S_ZFIN;
				end
				vfz_pkg::S_ZFIN: zl_q <= zw_q[15:0];
				vfz_pkg::S_SCWW: if (sw_q) ww_q <= scaled_v;
				vfz_pkg::S_SCWH: if (sh_q) wh_q <= scaled_v;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			vfz_pkg::S_IDLE: if (accept) begin
				tx_q <= target_x;
				ty_q <= target_y;
				tz_q <= target_zoom;
				zw_q <= DW'(tz_clamp);
				sw_q <= 1'b1;
				sh_q <= 1'b1;
			end
			vfz_pkg::S_EASE: begin
				dir_q <= ~gap[24];
				emul_q <= 56'(gap_mag) * 56'(EASE_RECIP);
			end
			vfz_pkg::S_FITA: begin
				off_q <= off_lo;
				hw_q <= hw_a;
			end
			vfz_pkg::S_FITB: if (off_q > hw_q) off_q <= hw_q;
			vfz_pkg::S_FITC: begin
				if (ax_q) top_q <= sat24(off_q);
				else left_q <= sat24(off_q);
			end
			vfz_pkg::S_ZOOM: begin
				sw_q <= 1'b1;
				sh_q <= 1'b1;
				if (zgap_mag <= {4'b0, zstep_q}) zw_q <= DW'(tz_q);
				else zw_q <= DW'(zn_clamp);
			end
			vfz_pkg::S_FITW2: begin
				zw_q <= quo;
				sw_q <= 1'b0;
				sh_q <= 1'b1;
			end
			vfz_pkg::S_FITH2: begin
				zw_q <= quo;
				sw_q <= 1'b1;
				sh_q <= 1'b0;
			end
			vfz_pkg::S_SCMW, vfz_pkg::S_SCMH: prod_q <= 40'(mul_a) * 40'(zw_q);
			vfz_pkg::S_DONE: if (out_free) begin
				ol_q <= left_q;
				ot_q <= top_q;
				ow_q <= ww_q;
				oh_q <= wh_q;
				oz_q <= zl_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign view_left = ol_q;
	assign view_top = ot_q;
	assign view_width = ow_q;
	assign view_height = oh_q;
	assign zoom_now = oz_q;

endmodule

// ----- sv/vfz_div.sv -----
// ----------------------------------------------------------------------------
// vfz_div: restoring unsigned divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module vfz_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vfz_pkg::div_req_t             req,
	output logic                          done,
	output logic [vfz_pkg::DVD_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(vfz_pkg::DVD_W + 1);

	logic [vfz_pkg::DVD_W-1:0] dq_q;
	logic [vfz_pkg::DVS_W:0]   rem_q;
	logic [vfz_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [vfz_pkg::DVS_W:0]   rem_sh;
	logic                      fits;

	assign rem_sh = {rem_q[vfz_pkg::DVS_W-1:0], dq_q[vfz_pkg::DVD_W-1]};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(vfz_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dq_q <= {dq_q[vfz_pkg::DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

endmodule

// ----- dv/viewport_follow_zoom_tb.sv -----
// ----------------------------------------------------------------------------
// viewport_follow_zoom_tb: self-checking bench for the follow/zoom camera
// Drives frame requests and register writes, predicts each window result in
// a scoreboard and compares every field of every accepted result.
// ----------------------------------------------------------------------------
module viewport_follow_zoom_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EASE_DIV = vfz_pkg::EASE_DIVISOR_DEF;
	localparam int Q24_HI = 8388607;
	localparam int Q24_LO = -8388608;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] top;
		logic [23:0]        width;
		logic [23:0]        height;
		logic [15:0]        zoom;
	} view_t;

	class view_scoreboard;
		int unsigned base_w, base_h, bnd_w, bnd_h, zlim, zstep;
		int bnd_l, bnd_t;
		int cx, cy;
		int unsigned zoom_lvl, win_w, win_h;
		view_t pending[$];
		int errors;

		function void reset_state();
			base_w = 640; base_h = 480; bnd_l = -1000; bnd_t = -1000;
			bnd_w = 3000; bnd_h = 3000; zlim = 4096; zstep = 41;
			cx = 0; cy = 0; zoom_lvl = 4096;
			win_w = base_w * 256; win_h = base_h * 256;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(vfz_pkg::reg_idx_t idx, logic [15:0] d);
			case (idx)
				vfz_pkg::REG_BASE_W: base_w = 32'(d[12:0]);
				vfz_pkg::REG_BASE_H: base_h = 32'(d[12:0]);
				vfz_pkg::REG_BND_L:  bnd_l = 32'($signed(d));
				vfz_pkg::REG_BND_T:  bnd_t = 32'($signed(d));
				vfz_pkg::REG_BND_W:  bnd_w = 32'(d[14:0]);
				vfz_pkg::REG_BND_H:  bnd_h = 32'(d[14:0]);
				vfz_pkg::REG_ZLIM:   zlim = 32'(d);
				vfz_pkg::REG_ZSTEP:  zstep = 32'(d[12:0]);
				default: ;
			endcase
		endfunction

		function int unsigned scale(int unsigned b, int unsigned z);
			longint v;
			v = (longint'(b) * longint'(z) + 8) >>> 4;
			return (v > 64'hFFFFFF) ? 32'hFFFFFF : 32'(v);
		endfunction

		function longint sat24(longint v);
			if (v > Q24_HI) return Q24_HI;
			if (v < Q24_LO) return Q24_LO;
			return v;
		endfunction

		// SV int division truncates toward zero, as needed here
		function int ease_axis(int p, int t);
			if (t > p) begin
				p += (t - p) / EASE_DIV;
				if (longint'((p + 128) / 256) * 256 >= t) p = t;
			end else if (t < p) begin
				p += (t - p) / EASE_DIV;
				if (longint'((p - 128) / 256) * 256 <= t) p = t;
			end
			return p;
		endfunction

		function int fit(int p, int unsigned w, int edge_px, int unsigned span,
				output longint corner);
			longint lo, hi, off;
			lo = longint'(edge_px) * 256;
			hi = lo + longint'(span) * 256;
			off = longint'(p) - longint'(w >> 1);
			if (off < lo) off = lo;
			if (off + longint'(w) > hi) off = hi - longint'(w);
			corner = sat24(off);
			return 32'(sat24(off + longint'(w >> 1)));
		endfunction

		function int unsigned clamp_z(longint z);
			if (z <= vfz_pkg::ZOOM_FLOOR) z = vfz_pkg::ZOOM_FLOOR;
			if (z > longint'(zlim)) z = zlim;
			return 32'(z);
		endfunction

		function void step_zoom(longint delta);
			int unsigned z;
			z = clamp_z(longint'(zoom_lvl) + delta);
			win_w = scale(base_w, z);
			win_h = scale(base_h, z);
			if (base_w != 0 && win_w > bnd_w * 256) begin
				z = (bnd_w << 12) / base_w;
				win_w = bnd_w * 256;
				win_h = scale(base_h, z);
			end
			if (base_h != 0 && win_h > bnd_h * 256) begin
				z = (bnd_h << 12) / base_h;
				win_h = bnd_h * 256;
				win_w = scale(base_w, z);
			end
			zoom_lvl = z & 32'hFFFF;
		endfunction

		function void note_request(logic signed [23:0] tx, logic signed [23:0] ty,
				logic [15:0] tz, logic jmp);
			longint l, t, gap;
			view_t v;
			if (jmp) begin
				cx = tx; cy = ty;
				zoom_lvl = clamp_z(longint'(tz));
				win_w = scale(base_w, zoom_lvl);
				win_h = scale(base_h, zoom_lvl);
			end
			cx = ease_axis(cx, tx);
			cy = ease_axis(cy, ty);
			cx = fit(cx, win_w, bnd_l, bnd_w, l);
			cy = fit(cy, win_h, bnd_t, bnd_h, t);
			if (zoom_lvl != 32'(tz)) begin
				gap = longint'(tz) - longint'(zoom_lvl);
				if (gap < 0) gap = -gap;
				if (gap <= longint'(zstep)) begin
					zoom_lvl = 32'(tz);
					win_w = scale(base_w, zoom_lvl);
					win_h = scale(base_h, zoom_lvl);
				end else if (zoom_lvl < 32'(tz)) step_zoom(longint'(zstep));
				else step_zoom(-longint'(zstep));
			end
			v.left = l[23:0]; v.top = t[23:0];
			v.width = win_w[23:0]; v.height = win_h[23:0]; v.zoom = zoom_lvl[15:0];
			pending.push_back(v);
		endfunction

		function void check_view(view_t a);
			view_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result left=%0d", $realtime, a.left);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.left !== e.left) begin
				$display("%0t: view_left exp %0d got %0d", $realtime, e.left, a.left);
				errors++;
			end
			if (a.top !== e.top) begin
				$display("%0t: view_top exp %0d got %0d", $realtime, e.top, a.top);
				errors++;
			end
			if (a.width !== e.width) begin
				$display("%0t: view_width exp %0d got %0d", $realtime, e.width, a.width);
				errors++;
			end
			if (a.height !== e.height) begin
				$display("%0t: view_height exp %0d got %0d", $realtime, e.height,
					a.height);
				errors++;
			end
			if (a.zoom !== e.zoom) begin
				$display("%0t: zoom_now exp %0d got %0d", $realtime, e.zoom, a.zoom);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic signed [23:0] target_x = 0, target_y = 0;
	logic [15:0] target_zoom = 0;
	logic jump = 0;
	logic signed [23:0] view_left, view_top;
	logic [23:0] view_width, view_height;
	logic [15:0] zoom_now;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	view_scoreboard sb;
	int gap_left = 0;
	bit hold_off = 0;

	viewport_follow_zoom dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stall pattern, plus one long hold-off
	always @(posedge clk) begin
		view_t r;
		if (out_valid && !out_stall) begin
			r.left = view_left; r.top = view_top; r.width = view_width;
			r.height = view_height; r.zoom = zoom_now;
			sb.check_view(r);
		end
		if (hold_off) out_stall <= 1;
		else case ($urandom_range(0, 2))
			0: out_stall <= ($urandom_range(0, 3) == 0);
			1: out_stall <= 0;
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic send_frame(logic signed [23:0] tx, logic signed [23:0] ty,
			logic [15:0] tz, logic jmp);
		if (gap_left == 0) gap_left = ($urandom_range(0, 3) == 0) ?
			-int'($urandom_range(1, 12)) : int'($urandom_range(1, 20));
		// negative count means idle cycles before the next burst
		if (gap_left < 0) in_valid <= 0;
		while (gap_left < 0) begin
			@(posedge clk);
			gap_left++;
		end
		in_valid <= 1; target_x <= tx; target_y <= ty; target_zoom <= tz; jump <= jmp;
		do @(posedge clk); while (in_stall);
		sb.note_request(tx, ty, tz, jmp);
		gap_left--;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(vfz_pkg::reg_idx_t idx, logic [15:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_pos(int unsigned spread);
		if ($urandom_range(0, 9) == 0) return 24'($urandom);
		return 24'($signed($urandom_range(0, 2 * spread)) - $signed(spread));
	endfunction

	task automatic random_frames(int n, int unsigned spread);
		logic [15:0] tz;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: tz = 16'($urandom);
				1: tz = 16'(sb.zoom_lvl + $urandom_range(0, 2 * sb.zstep) - sb.zstep);
				default: tz = 16'($urandom_range(600, 9000));
			endcase
			send_frame(rand_pos(spread), rand_pos(spread), tz, $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		sb = new();
		sb.reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, jump, snaps, clamps
		send_frame(24'sd0, 24'sd0, 16'd4096, 1'b0);
		send_frame(24'sh7FFFFF, 24'sh800000, 16'hFFFF, 1'b1);
		send_frame(24'sh800000, 24'sh7FFFFF, 16'd0, 1'b1);
		send_frame(24'sd300, -24'sd300, 16'd819, 1'b0);
		send_frame(24'sd5000, 24'sd5000, 16'd4100, 1'b1);
		send_frame(24'sd5000, 24'sd5000, 16'd4096, 1'b0);
		send_frame(-24'sd200000, 24'sd200000, 16'd8000, 1'b0);
		send_frame(24'sh555555, 24'shAAAAAA, 16'hAAAA, 1'b0);
		send_frame(24'shAAAAAA, 24'sh555555, 16'h5555, 1'b1);
		send_frame(24'sd10, -24'sd10, 16'd818, 1'b1);
		send_frame(24'sd1000, 24'sd1000, 16'd820, 1'b0);
		drain();

		// larger zoom limit, tight boundary: fit-to-boundary paths
		write_reg(vfz_pkg::REG_ZLIM, 16'hFFFF);
		write_reg(vfz_pkg::REG_BND_W, 16'd200);
		write_reg(vfz_pkg::REG_BND_H, 16'h7FFF);
		write_reg(vfz_pkg::REG_ZSTEP, 16'd4096);
		send_frame(24'sd0, 24'sd0, 16'hFFFF, 1'b0);
		send_frame(24'sd0, 24'sd0, 16'hFFFF, 1'b0);
		send_frame(24'sd0, 24'sd0, 16'hFFFF, 1'b1);
		random_frames(300, 400000);
		drain();

		// extremes of all registers
		write_reg(vfz_pkg::REG_BASE_W, 16'd4096);
		write_reg(vfz_pkg::REG_BASE_H, 16'd1);
		write_reg(vfz_pkg::REG_BND_L, 16'h8000);
		write_reg(vfz_pkg::REG_BND_T, 16'h7FFF);
		write_reg(vfz_pkg::REG_BND_W, 16'h7FFF);
		write_reg(vfz_pkg::REG_BND_H, 16'd1);
		write_reg(vfz_pkg::REG_ZLIM, 16'd819);
		write_reg(vfz_pkg::REG_ZSTEP, 16'd0);
		random_frames(300, 8388607);
		drain();

		write_reg(vfz_pkg::REG_BASE_W, 16'd1);
		write_reg(vfz_pkg::REG_BASE_H, 16'd4096);
		write_reg(vfz_pkg::REG_BND_L, 16'd0);
		write_reg(vfz_pkg::REG_BND_T, 16'hFFFF);
		write_reg(vfz_pkg::REG_BND_W, 16'd1);
		write_reg(vfz_pkg::REG_BND_H, 16'h7FFF);
		write_reg(vfz_pkg::REG_ZLIM, 16'd100);
		write_reg(vfz_pkg::REG_ZSTEP, 16'h1FFF);
		random_frames(250, 8388607);
		drain();

		// moderate setup with a long receiver hold-off
		write_reg(vfz_pkg::REG_BASE_W, 16'd320);
		write_reg(vfz_pkg::REG_BASE_H, 16'd240);
		write_reg(vfz_pkg::REG_BND_L, -16'sd500);
		write_reg(vfz_pkg::REG_BND_T, -16'sd400);
		write_reg(vfz_pkg::REG_BND_W, 16'd2000);
		write_reg(vfz_pkg::REG_BND_H, 16'd1500);
		write_reg(vfz_pkg::REG_ZLIM, 16'd16384);
		write_reg(vfz_pkg::REG_ZSTEP, 16'd100);
		hold_off = 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			random_frames(50, 300000);
		join
		random_frames(900, 300000);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

// ----- files.f -----
sv/vfz_pkg.sv
sv/vfz_div.sv
sv/viewport_follow_zoom.sv
dv/viewport_follow_zoom_tb.sv
